FILE: hw/rtl/cfo_pkg.sv
// Shared types and constants for the circular FIFO with overwrite.
// No dependencies; imported by the interfaces, the core, the scoreboard and the testbench.
package cfo_pkg;

  // Default storage geometry
  localparam int CFO_DEPTH      = 128;
  localparam int CFO_DATA_WIDTH = 32;

  // Fixed field widths
  localparam int COUNT_W  = 7;
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd127;

  // Register index (byte address divided by four)
  localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH      = 2'd0,
    KIND_POP       = 2'd1,
    KIND_OVERWRITE = 2'd2,
    KIND_READ_AT   = 2'd3
  } kind_t;

endpackage

FILE: hw/rtl/cfo_if.sv
// Valid/ready channel interfaces for the FIFO command and response streams.
// Depends on cfo_pkg for the field widths.
interface cfo_cmd_if import cfo_pkg::*; #(
  parameter int DATA_WIDTH = CFO_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [DATA_WIDTH-1:0] value;
  logic [INDEX_W-1:0]    index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

interface cfo_rsp_if import cfo_pkg::*; #(
  parameter int DATA_WIDTH = CFO_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] read_data;
  logic                  index_error;
  logic [COUNT_W-1:0]    count;
  logic                  full_res;
  logic                  empty_res;
  logic                  overflow;
  logic                  underflow;

  modport source (output valid, read_data, index_error, count, full_res, empty_res,
                  overflow, underflow, input ready);
  modport sink   (input valid, read_data, index_error, count, full_res, empty_res,
                  overflow, underflow, output ready);
endinterface

FILE: hw/rtl/circular_fifo_with_overwrite_core.sv
// Circular FIFO with overwrite: ring of min(capacity+1, DEPTH) slots, one kept empty.
// Each result passes through stage 1 (RAM registered read) and then the response register.
// Throughput: one command per cycle while responses are taken; each item makes at most one RAM access.
// Reset (synchronous): capacity 127, queue empty, flags clear; slot RAM is not cleared.
// Depends on cfo_pkg, cfo_if (cfo_cmd_if, cfo_rsp_if) and cfo_ram.
module circular_fifo_with_overwrite_core import cfo_pkg::*; #(
  parameter int DEPTH      = CFO_DEPTH,
  parameter int DATA_WIDTH = CFO_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  cfo_cmd_if.sink            cmd,
  cfo_rsp_if.source          rsp
);

  // Slot address width, a width that holds DEPTH and capacity+1, and one more for sums
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = (AW + 1 > COUNT_W + 1) ? AW + 1 : COUNT_W + 1;
  localparam int SW = NW + 1;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] capacity;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ?
                  {{(PDATA_W-COUNT_W){1'b0}}, capacity} : '0;

  // ---------------------------------------------------------------------------
  // Queue state
  // ---------------------------------------------------------------------------
  logic [AW-1:0]      wr_pos, wr_pos_next;
  logic [AW-1:0]      rd_pos, rd_pos_next;
  logic [COUNT_W-1:0] held, held_next;
  logic               over_flag, over_flag_next;
  logic               under_flag, under_flag_next;

  // Ring length: capacity+1, limited to DEPTH
  logic [NW-1:0] cap_p1;
  logic [NW-1:0] ring_n;

  assign cap_p1 = NW'(capacity) + NW'(1);
  assign ring_n = (cap_p1 > NW'(DEPTH)) ? NW'(DEPTH) : cap_p1;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [NW-1:0] n);
    logic [NW-1:0] s;
    s = NW'(p) + NW'(1);
    return (s >= n) ? '0 : s[AW-1:0];
  endfunction

  function automatic logic is_full(input logic [COUNT_W-1:0] h, input logic [NW-1:0] n);
    return NW'(h) >= (n - NW'(1));
  endfunction

  // ---------------------------------------------------------------------------
  // Command decode: next state and RAM access for the item on the channel
  // ---------------------------------------------------------------------------
  logic            cmd_xfer;
  logic            full_now;
  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic            take_data;
  logic            idx_err;
  logic [SW-1:0]   age_sum;
  logic [SW-1:0]   age_pos;

  assign full_now = is_full(held, ring_n);

  // Slot at an age index, wrapped once around the ring
  always_comb begin
    age_sum = SW'(rd_pos) + SW'(cmd.index);
    age_pos = (age_sum >= SW'(ring_n)) ? age_sum - SW'(ring_n) : age_sum;
  end

  always_comb begin
    wr_pos_next     = wr_pos;
    rd_pos_next     = rd_pos;
    held_next       = held;
    over_flag_next  = over_flag;
    under_flag_next = under_flag;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = rd_pos;
    take_data       = 1'b0;
    idx_err         = 1'b0;

    unique case (kind_t'(cmd.kind))
      KIND_PUSH: begin
        if (full_now) begin
          over_flag_next = 1'b1;
        end else begin
          under_flag_next = 1'b0;
          ram_we          = 1'b1;
          wr_pos_next     = advance(wr_pos, ring_n);
          held_next       = held + COUNT_W'(1);
        end
      end
      KIND_POP: begin
        if (held == '0) begin
          under_flag_next = 1'b1;
        end else begin
          ram_re         = 1'b1;
          take_data      = 1'b1;
          over_flag_next = 1'b0;
          rd_pos_next    = advance(rd_pos, ring_n);
          held_next      = held - COUNT_W'(1);
        end
      end
      KIND_OVERWRITE: begin
        if (full_now && (held == '0)) begin
          // Single-slot ring: the drop underflows and the push overflows
          under_flag_next = 1'b1;
          over_flag_next  = 1'b1;
        end else if (full_now) begin
          // Drop the oldest word, then store; count stays the same
          over_flag_next  = 1'b0;
          under_flag_next = 1'b0;
          ram_we          = 1'b1;
          rd_pos_next     = advance(rd_pos, ring_n);
          wr_pos_next     = advance(wr_pos, ring_n);
        end else begin
          under_flag_next = 1'b0;
          ram_we          = 1'b1;
          wr_pos_next     = advance(wr_pos, ring_n);
          held_next       = held + COUNT_W'(1);
        end
      end
      KIND_READ_AT: begin
        if (cmd.index >= held) begin
          idx_err = 1'b1;
        end else begin
          ram_re    = 1'b1;
          take_data = 1'b1;
          ram_raddr = age_pos[AW-1:0];
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Slot storage
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] ram_rdata;

  cfo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (cmd_xfer && ram_we),
    .waddr (wr_pos),
    .wdata (cmd.value),
    .re    (cmd_xfer && ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Pipeline: stage 1 waits for RAM data, then the response register holds the result
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  logic               s1_take;
  logic               s1_err;
  logic [COUNT_W-1:0] s1_count;
  logic               s1_full;
  logic               s1_empty;
  logic               s1_over;
  logic               s1_under;
  logic               s1_adv;
  logic               out_valid;

  // Stage 1 stalls only while the response register is occupied and not taken;
  // no new read is issued then, so the RAM keeps its read data.
  // Hold ready low during reset so no transfer is taken then.
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !rst && (!s1_valid || s1_adv);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      wr_pos     <= '0;
      rd_pos     <= '0;
      held       <= '0;
      over_flag  <= 1'b0;
      under_flag <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        // New capacity flushes the queue; stored words become unreachable
        capacity   <= pwdata[COUNT_W-1:0];
        wr_pos     <= '0;
        rd_pos     <= '0;
        held       <= '0;
        over_flag  <= 1'b0;
        under_flag <= 1'b0;
      end else if (cmd_xfer) begin
        wr_pos     <= wr_pos_next;
        rd_pos     <= rd_pos_next;
        held       <= held_next;
        over_flag  <= over_flag_next;
        under_flag <= under_flag_next;
      end

      if (cmd_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      s1_take  <= take_data;
      s1_err   <= idx_err;
      s1_count <= held_next;
      s1_full  <= is_full(held_next, ring_n);
      s1_empty <= (held_next == '0);
      s1_over  <= over_flag_next;
      s1_under <= under_flag_next;
    end
    if (s1_adv) begin
      rsp.read_data   <= s1_take ? ram_rdata : '0;
      rsp.index_error <= s1_err;
      rsp.count       <= s1_count;
      rsp.full_res    <= s1_full;
      rsp.empty_res   <= s1_empty;
      rsp.overflow    <= s1_over;
      rsp.underflow   <= s1_under;
    end
  end

endmodule

FILE: hw/rtl/cfo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the FIFO slot storage.
module cfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Hold read data when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: test/cfo_mirror_pkg.sv
// Scoreboard for the circular FIFO with overwrite: a shadow ring buffer and
// the queue of responses it predicts. Depends on cfo_pkg for kinds and widths.
package cfo_mirror_pkg;
  import cfo_pkg::*;

  typedef struct packed {
    logic [CFO_DATA_WIDTH-1:0] read_data;
    logic                      index_error;
    logic [COUNT_W-1:0]        count;
    logic                      full_res;
    logic                      empty_res;
    logic                      overflow;
    logic                      underflow;
  } fifo_rsp_t;

  class fifo_mirror;
    bit [CFO_DATA_WIDTH-1:0] words [CFO_DEPTH];
    int unsigned wr_pos, rd_pos, held, capacity;
    bit          over_flag, under_flag;
    fifo_rsp_t   pending_rsp [$];
    int unsigned mismatches, checked, settings;
    int unsigned peak_held, overflow_hits, underflow_hits, index_misses;

    function new();
      capacity = 32'(CAPACITY_RESET);
      flush();
    endfunction

    function void flush();
      wr_pos     = 0;
      rd_pos     = 0;
      held       = 0;
      over_flag  = 1'b0;
      under_flag = 1'b0;
    endfunction

    // A capacity write empties the queue; stored words stay but are unreachable.
    function void set_capacity(int unsigned c);
      capacity = c & 32'h7f;
      settings++;
      flush();
    endfunction

    function int unsigned ring_size();
      int unsigned n;
      n = capacity + 1;
      return (n > CFO_DEPTH) ? CFO_DEPTH : n;
    endfunction

    function int unsigned step_pos(int unsigned p);
      return (p + 1 >= ring_size()) ? 0 : p + 1;
    endfunction

    function bit is_full();
      return held >= ring_size() - 1;
    endfunction

    function void push_word(bit [CFO_DATA_WIDTH-1:0] v);
      if (is_full()) begin
        over_flag = 1'b1;
        overflow_hits++;
        return;
      end
      under_flag     = 1'b0;
      words[wr_pos]  = v;
      wr_pos         = step_pos(wr_pos);
      held++;
      if (held > peak_held) peak_held = held;
    endfunction

    function bit [CFO_DATA_WIDTH-1:0] pop_word();
      bit [CFO_DATA_WIDTH-1:0] v;
      if (held == 0) begin
        under_flag = 1'b1;
        underflow_hits++;
        return '0;
      end
      v         = words[rd_pos];
      over_flag = 1'b0;
      rd_pos    = step_pos(rd_pos);
      held--;
      return v;
    endfunction

    // Apply one accepted command and queue the response it must produce.
    function void note_command(kind_t k, bit [CFO_DATA_WIDTH-1:0] v, bit [INDEX_W-1:0] idx);
      fifo_rsp_t   e;
      int unsigned p;
      e = '0;
      case (k)
        KIND_PUSH: push_word(v);
        KIND_POP:  e.read_data = pop_word();
        KIND_OVERWRITE: begin
          if (is_full()) void'(pop_word());
          push_word(v);
        end
        default: begin
          if (idx >= held) begin
            e.index_error = 1'b1;
            index_misses++;
          end else begin
            p = rd_pos + idx;
            if (p >= ring_size()) p -= ring_size();
            e.read_data = words[p];
          end
        end
      endcase
      e.count     = held[COUNT_W-1:0];
      e.full_res  = is_full();
      e.empty_res = (held == 0);
      e.overflow  = over_flag;
      e.underflow = under_flag;
      pending_rsp.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
        mismatches++;
      end
    endfunction

    function void check_response(fifo_rsp_t act);
      fifo_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response transfer with no command waiting for it");
        mismatches++;
        return;
      end
      e = pending_rsp.pop_front();
      checked++;
      compare_field("read_data",   32'(e.read_data),   32'(act.read_data));
      compare_field("index_error", 32'(e.index_error), 32'(act.index_error));
      compare_field("count",       32'(e.count),       32'(act.count));
      compare_field("full_res",    32'(e.full_res),    32'(act.full_res));
      compare_field("empty_res",   32'(e.empty_res),   32'(act.empty_res));
      compare_field("overflow",    32'(e.overflow),    32'(act.overflow));
      compare_field("underflow",   32'(e.underflow),   32'(act.underflow));
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
// Top-level testbench for circular_fifo_with_overwrite_core: drives commands and
// capacity writes, checks every response against the fifo_mirror scoreboard.
// Depends on cfo_pkg, cfo_if (cfo_cmd_if, cfo_rsp_if) and cfo_mirror_pkg.
module tb_top;
  import cfo_pkg::*;
  import cfo_mirror_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 300;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  cfo_cmd_if cmd_ch ();
  cfo_rsp_if rsp_ch ();

  circular_fifo_with_overwrite_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch)
  );

  fifo_mirror mirror = new();

  // Idle rates in percent, set per phase by the stimulus process.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests = 0;
  int unsigned cycles        = 0;
  // Steer random kinds toward filling or draining the queue.
  bit          filling       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if it overstays the cycle budget.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Response side: check each transfer, then pick ready for the next edge.
  // A pending hold-off request keeps ready low until hold_left, loaded with LONG_HOLD, counts down here.
  initial begin
    fifo_rsp_t   act;
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left    = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        act.read_data   = rsp_ch.read_data;
        act.index_error = rsp_ch.index_error;
        act.count       = rsp_ch.count;
        act.full_res    = rsp_ch.full_res;
        act.empty_res   = rsp_ch.empty_res;
        act.overflow    = rsp_ch.overflow;
        act.underflow   = rsp_ch.underflow;
        mirror.check_response(act);
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one command, idling first at the sender's rate; return right after
  // the transfer edge with valid still high, so back-to-back items never drop it.
  task automatic send_cmd(kind_t k, logic [31:0] v, logic [INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind  <= k;
    cmd_ch.value <= v;
    cmd_ch.index <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    mirror.note_command(k, v, idx);
  endtask

  // Drop valid and hold until every predicted response has been checked.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the capacity register, then a read back of its low bits.
  task automatic write_capacity(int unsigned c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= c;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mirror.set_capacity(c);
    // Chain straight into a read transfer: setup, then access.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== c[COUNT_W-1:0]) begin
      $error("capacity mismatch: expected %0h, actual %0h", c[COUNT_W-1:0],
             prdata[COUNT_W-1:0]);
      mirror.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random command, biased so the queue swings between empty and full.
  task automatic send_random();
    kind_t              k;
    logic [31:0]        v;
    logic [INDEX_W-1:0] idx;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 45)      k = KIND_PUSH;
      else if (r < 70) k = KIND_OVERWRITE;
      else if (r < 80) k = KIND_POP;
      else             k = KIND_READ_AT;
    end else begin
      if (r < 10)      k = KIND_PUSH;
      else if (r < 15) k = KIND_OVERWRITE;
      else if (r < 80) k = KIND_POP;
      else             k = KIND_READ_AT;
    end
    r = $urandom_range(0, 99);
    if (r < 8)       v = '0;
    else if (r < 16) v = '1;
    else             v = $urandom();
    // Mostly in-range age indexes; the rest are drawn from 0 to 126 and can probe past the count.
    if (mirror.held > 0 && $urandom_range(0, 99) < 75)
      idx = INDEX_W'($urandom_range(0, mirror.held - 1));
    else
      idx = INDEX_W'($urandom_range(0, 126));
    send_cmd(k, v, idx);
    // Linger at full and empty for a while before turning around.
    if (filling && mirror.is_full() && $urandom_range(0, 5) == 0)
      filling = 1'b0;
    else if (!filling && mirror.held == 0 && $urandom_range(0, 5) == 0)
      filling = 1'b1;
    else if ($urandom_range(0, 149) == 0)
      filling = !filling;
  endtask

  // Reconfigure while idle, then run n random commands at the given idle rates.
  // hold_off asks for a long receiver stall a quarter in; pause makes the sender
  // wait for every response halfway through.
  task automatic run_phase(int unsigned cap, int unsigned n, int unsigned s_pct,
                           int unsigned r_pct, bit hold_off, bit pause);
    drain_results();
    write_capacity(cap);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    filling       = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (hold_off && i == n / 4) hold_requests++;
      if (pause && i == n / 2) drain_results();
      send_random();
    end
  endtask

  initial begin
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.kind    <= KIND_PUSH;
    cmd_ch.value   <= '0;
    cmd_ch.index   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, empty-queue errors, extreme words and indexes.
    recv_idle_pct = 30;
    send_cmd(KIND_POP,     32'h1234_5678, 7'd0);
    send_cmd(KIND_READ_AT, '0,            7'd0);
    send_cmd(KIND_PUSH,    32'h0000_0000, 7'd0);
    send_cmd(KIND_PUSH,    32'hFFFF_FFFF, 7'd127);
    send_cmd(KIND_READ_AT, '0,            7'd1);
    send_cmd(KIND_READ_AT, '0,            7'd126);
    send_cmd(KIND_POP,     '0,            7'd0);

    // Capacity two: fill, push on full, overwrite drops the oldest, reads, drain.
    drain_results();
    write_capacity(2);
    send_cmd(KIND_PUSH,      32'hA5A5_0001, 7'd0);
    send_cmd(KIND_PUSH,      32'h5A5A_0002, 7'd0);
    send_cmd(KIND_PUSH,      32'hDEAD_0003, 7'd0);
    send_cmd(KIND_OVERWRITE, 32'hBEEF_0004, 7'd0);
    send_cmd(KIND_READ_AT,   '0,            7'd0);
    send_cmd(KIND_READ_AT,   '0,            7'd1);
    send_cmd(KIND_READ_AT,   '0,            7'd2);
    send_cmd(KIND_POP,       '0,            7'd0);
    send_cmd(KIND_POP,       '0,            7'd0);
    send_cmd(KIND_POP,       '0,            7'd0);

    // Capacity zero: always full and empty; overwrite sets both flags.
    drain_results();
    write_capacity(0);
    send_cmd(KIND_PUSH,      32'h0000_0042, 7'd0);
    send_cmd(KIND_POP,       '0,            7'd0);
    send_cmd(KIND_OVERWRITE, 32'h0000_0043, 7'd0);
    send_cmd(KIND_READ_AT,   '0,            7'd0);

    // Random phases: sender light / receiver heavy idling, then swapped, then none.
    run_phase(1,                       100, 7,  64, 1'b0, 1'b0);
    run_phase(127,                     250, 7,  64, 1'b1, 1'b0);
    run_phase(8,                       150, 64, 7,  1'b0, 1'b0);
    run_phase(127,                     200, 64, 7,  1'b0, 1'b0);
    run_phase(3,                       100, 0,  0,  1'b0, 1'b1);
    run_phase($urandom_range(1, 127),  150, 0,  0,  1'b1, 1'b0);
    run_phase(16,                      100, 0,  0,  1'b0, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);

    $display("Checked %0d responses across %0d capacity settings; peak occupancy %0d.",
             mirror.checked, mirror.settings, mirror.peak_held);
    $display("Saw %0d pushes on full, %0d pops on empty, %0d out-of-range reads.",
             mirror.overflow_hits, mirror.underflow_hits, mirror.index_misses);
    if (mirror.mismatches == 0 && mirror.pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
